[sv/sample_playback_voice_mixer_unit_macros.svh]
// Assertion macros for the sample playback voice mixer checker.
// Depends on nothing; included by the checker file only.
`ifndef SAMPLE_PLAYBACK_VOICE_MIXER_UNIT_MACROS_SVH
`define SAMPLE_PLAYBACK_VOICE_MIXER_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SPVM_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spvm checker: assertion failed");

// Consequent checked in the cycle after the antecedent.
`define SPVM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spvm checker: assertion failed");

`endif

[sv/spvm_pkg.sv]
// Shared types, constants and helpers of the sample playback voice mixer.
// Depends on nothing; used by every module of the block.
`default_nettype none

package spvm_pkg;

  localparam int SAMPLE_DEPTH_DEF = 65536;
  localparam int SAMPLE_BITS_DEF  = 16;

  localparam int POS_W      = 34;
  localparam int FRAC_W     = 16;
  localparam int POS_INT_W  = POS_W - FRAC_W;
  localparam int LEN_W      = 17;
  localparam int STEP_W     = 24;
  localparam int VOL_W      = 16;
  localparam int PAN_W      = 16;
  localparam int FACTOR_W   = 17;
  localparam int MIX_W      = 24;
  localparam int ACC_W      = 33;
  localparam int HALF_W     = 16;
  localparam int WORD_W     = 2 * HALF_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int MOD_STEPS  = POS_INT_W;

  localparam logic [STEP_W-1:0] STEP_RESET   = 24'd65536;
  localparam logic [LEN_W-1:0]  LEN_RESET    = 17'd1;
  localparam logic [VOL_W-1:0]  VOL_RESET    = 16'd4096;
  localparam logic [PAN_W-1:0]  PAN_RESET    = 16'd0;
  localparam logic [FACTOR_W-1:0] FACTOR_MONO = 17'h10000;
  localparam logic signed [PAN_W+1:0] PAN_CENTER = 18'sd32768;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 33'sd8388607;
  localparam logic signed [ACC_W-1:0] ACC_MIN = -33'sd8388608;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2,
    OP_RENDER = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POSITION_STEP    = 3'd0,
    CFG_SOUND_LENGTH     = 3'd1,
    CFG_LOOP_ENABLE      = 3'd2,
    CFG_SOURCE_IS_STEREO = 3'd3,
    CFG_OUTPUT_IS_STEREO = 3'd4,
    CFG_VOLUME_GAIN      = 3'd5,
    CFG_PAN_POSITION     = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ADDR_MOD,
    S_WRITE,
    S_POS_MOD,
    S_READ0,
    S_READ1,
    S_LERP,
    S_INTERP,
    S_VOL,
    S_PAN,
    S_ACC,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t                      opcode;
    logic [15:0]              load_address;
    logic signed [HALF_W-1:0] load_left;
    logic signed [HALF_W-1:0] load_right;
    logic signed [MIX_W-1:0]  mix_in_left;
    logic signed [MIX_W-1:0]  mix_in_right;
  } in_item_t;

  typedef struct packed {
    logic signed [MIX_W-1:0] mix_out_left;
    logic signed [MIX_W-1:0] mix_out_right;
    logic                    voice_playing;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic mod_start;
    logic mod_sel_pos;
    logic mem_write;
    logic pos_from_mod;
    logic rd_second;
    logic lerp;
    logic interp;
    logic vol;
    logic pan;
    logic acc;
    logic voice_start;
    logic voice_stop;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic addr_ok;
    logic active;
    logic len_zero;
    logic past_end;
    logic loop_en;
    logic mod_busy;
  } ctrl_status_t;

  function automatic logic signed [MIX_W-1:0] sat_mix(input logic signed [ACC_W-1:0] x);
    logic signed [MIX_W-1:0] r;
    if (x > ACC_MAX) begin
      r = ACC_MAX[MIX_W-1:0];
    end else if (x < ACC_MIN) begin
      r = ACC_MIN[MIX_W-1:0];
    end else begin
      r = x[MIX_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/spvm_remainder.sv]
// Restoring remainder unit: one quotient bit per cycle over the play position width.
// Depends on spvm_pkg.
`default_nettype none

module spvm_remainder #(
  parameter int DIV_W = spvm_pkg::LEN_W
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [spvm_pkg::POS_INT_W-1:0] dividend,
  input  wire logic [DIV_W-1:0]               divisor,
  output logic                                busy,
  output logic [DIV_W-1:0]                    rem
);

  localparam int CNT_W = $clog2(spvm_pkg::MOD_STEPS + 1);

  logic [CNT_W-1:0]               cnt;
  logic [spvm_pkg::POS_INT_W-1:0] dvd;
  logic [DIV_W-1:0]               div_q;
  logic [DIV_W:0]                 trial;
  logic [DIV_W-1:0]               rem_next;

  // Shift the next dividend bit into the partial remainder; it stays below
  // twice the divisor, so one subtraction restores it.
  always_comb begin
    trial = {rem, dvd[spvm_pkg::POS_INT_W-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_next = DIV_W'(trial - {1'b0, div_q});
    end else begin
      rem_next = trial[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(spvm_pkg::MOD_STEPS);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      dvd   <= dividend;
      div_q <= divisor;
    end else if (cnt != '0) begin
      rem <= rem_next;
      dvd <= {dvd[spvm_pkg::POS_INT_W-2:0], 1'b0};
    end
  end

  assign busy = (cnt != '0);

endmodule

`default_nettype wire

[sv/spvm_datapath.sv]
// Datapath of the voice: configuration registers, sample memory, play position,
// interpolation, gain multipliers and mix saturation. Depends on spvm_pkg, spvm_remainder.
`default_nettype none

module spvm_datapath #(
  parameter int SAMPLE_DEPTH = spvm_pkg::SAMPLE_DEPTH_DEF,
  parameter int SAMPLE_BITS  = spvm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [spvm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [spvm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire spvm_pkg::in_item_t              in_data,
  input  wire spvm_pkg::ctrl_cmd_t             cmd,
  output spvm_pkg::ctrl_status_t               status,
  output spvm_pkg::out_item_t                  out_data
);

  localparam int SB      = SAMPLE_BITS;
  localparam int AW      = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int DEPTH_W = $clog2(SAMPLE_DEPTH + 1);
  localparam int DIV_W   = (DEPTH_W > spvm_pkg::LEN_W) ? DEPTH_W : spvm_pkg::LEN_W;
  localparam int DW      = SB + 1;
  localparam int LP_W    = DW + spvm_pkg::FRAC_W + 1;
  localparam int VP_W    = DW + spvm_pkg::VOL_W + 1;
  localparam int PP_W    = VP_W + spvm_pkg::FACTOR_W + 1;
  localparam int SHIFT   = SB + 4;
  localparam int PI_W    = spvm_pkg::POS_INT_W;

  // Configuration registers.
  logic [spvm_pkg::STEP_W-1:0]       position_step;
  logic [spvm_pkg::LEN_W-1:0]        sound_length;
  logic                              loop_enable;
  logic                              source_is_stereo;
  logic                              output_is_stereo;
  logic [spvm_pkg::VOL_W-1:0]        volume_gain;
  logic signed [spvm_pkg::PAN_W-1:0] pan_position;

  always_ff @(posedge clk) begin
    if (rst) begin
      position_step    <= spvm_pkg::STEP_RESET;
      sound_length     <= spvm_pkg::LEN_RESET;
      loop_enable      <= 1'b0;
      source_is_stereo <= 1'b0;
      output_is_stereo <= 1'b1;
      volume_gain      <= spvm_pkg::VOL_RESET;
      pan_position     <= spvm_pkg::PAN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        spvm_pkg::CFG_POSITION_STEP: begin
          position_step <= cfg_data[spvm_pkg::STEP_W-1:0];
        end
        spvm_pkg::CFG_SOUND_LENGTH: begin
          sound_length <= cfg_data[spvm_pkg::LEN_W-1:0];
        end
        spvm_pkg::CFG_LOOP_ENABLE: begin
          loop_enable <= cfg_data[0];
        end
        spvm_pkg::CFG_SOURCE_IS_STEREO: begin
          source_is_stereo <= cfg_data[0];
        end
        spvm_pkg::CFG_OUTPUT_IS_STEREO: begin
          output_is_stereo <= cfg_data[0];
        end
        spvm_pkg::CFG_VOLUME_GAIN: begin
          volume_gain <= cfg_data[spvm_pkg::VOL_W-1:0];
        end
        spvm_pkg::CFG_PAN_POSITION: begin
          pan_position <= cfg_data[spvm_pkg::PAN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Accepted word and voice state.
  spvm_pkg::in_item_t          item;
  logic [spvm_pkg::POS_W-1:0]  pos;
  logic                        active;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_data;
    end
  end

  // Effective length and position decode.
  logic [DIV_W-1:0]              len_full;
  logic [spvm_pkg::LEN_W-1:0]    len;
  logic [PI_W-1:0]               pos_int;
  logic [PI_W-1:0]               len_ext;
  logic [PI_W-1:0]               i0p1;
  logic [PI_W-1:0]               i1;
  logic [spvm_pkg::FRAC_W-1:0]   frac;
  logic                          addr_ok;

  assign len_full = (DIV_W'(sound_length) < DIV_W'(SAMPLE_DEPTH)) ?
                    DIV_W'(sound_length) : DIV_W'(SAMPLE_DEPTH);
  assign len      = spvm_pkg::LEN_W'(len_full);
  assign len_ext  = PI_W'(len);
  assign pos_int  = pos[spvm_pkg::POS_W-1:spvm_pkg::FRAC_W];
  assign frac     = pos[spvm_pkg::FRAC_W-1:0];
  assign i0p1     = pos_int + 1'b1;
  assign i1       = (i0p1 < len_ext) ? i0p1 : (loop_enable ? '0 : pos_int);
  assign addr_ok  = DIV_W'(item.load_address) < DIV_W'(SAMPLE_DEPTH);

  // Shared remainder unit: load address modulo depth, or wrap of the position.
  logic [PI_W-1:0]  mod_dividend;
  logic [DIV_W-1:0] mod_divisor;
  logic [DIV_W-1:0] mod_rem;
  logic             mod_busy;

  assign mod_dividend = cmd.mod_sel_pos ? pos_int : PI_W'(item.load_address);
  assign mod_divisor  = cmd.mod_sel_pos ? DIV_W'(len) : DIV_W'(SAMPLE_DEPTH);

  spvm_remainder #(
    .DIV_W (DIV_W)
  ) u_remainder (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mod_start),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .busy     (mod_busy),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      active <= 1'b0;
    end else begin
      if (cmd.voice_start) begin
        pos    <= '0;
        active <= 1'b1;
      end else if (cmd.pos_from_mod) begin
        pos[spvm_pkg::POS_W-1:spvm_pkg::FRAC_W] <= PI_W'(mod_rem);
      end else if (cmd.acc) begin
        pos <= pos + spvm_pkg::POS_W'(position_step);
      end
      if (cmd.voice_stop) begin
        active <= 1'b0;
      end
    end
  end

  // Sample memory: one write port, one registered read port. The first
  // frame is read, then the second while the first is held in w0.
  logic [spvm_pkg::WORD_W-1:0] mem [0:SAMPLE_DEPTH-1];
  logic [spvm_pkg::WORD_W-1:0] rd_data;
  logic [spvm_pkg::WORD_W-1:0] w0;
  logic [AW-1:0]               rd_addr;
  logic [AW-1:0]               wr_addr;

  assign rd_addr = cmd.rd_second ? AW'(i1) : AW'(pos_int);
  assign wr_addr = addr_ok ? AW'(item.load_address) : AW'(mod_rem);

  always_ff @(posedge clk) begin
    if (cmd.mem_write) begin
      mem[wr_addr] <= {item.load_right, item.load_left};
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (cmd.rd_second) begin
      w0 <= rd_data;
    end
  end

  // Interpolation.
  logic signed [SB-1:0]  a_l, a_r, b_l, b_r;
  logic signed [DW-1:0]  diff_l, diff_r;
  logic signed [spvm_pkg::FRAC_W:0] frac_s;
  logic signed [LP_W-1:0] prod_l, prod_r;

  assign a_l    = SB'($signed(w0[spvm_pkg::HALF_W-1:0]));
  assign a_r    = SB'($signed(w0[spvm_pkg::WORD_W-1:spvm_pkg::HALF_W]));
  assign b_l    = SB'($signed(rd_data[spvm_pkg::HALF_W-1:0]));
  assign b_r    = SB'($signed(rd_data[spvm_pkg::WORD_W-1:spvm_pkg::HALF_W]));
  assign diff_l = DW'(b_l) - DW'(a_l);
  assign diff_r = DW'(b_r) - DW'(a_r);
  assign frac_s = $signed({1'b0, frac});

  always_ff @(posedge clk) begin
    if (cmd.lerp) begin
      prod_l <= diff_l * frac_s;
      prod_r <= diff_r * frac_s;
    end
  end

  logic signed [DW:0]   lerp_l, lerp_r, src_r;
  logic signed [DW+1:0] avg;
  logic signed [DW-1:0] smp_l, smp_r;

  assign lerp_l = (DW + 1)'(a_l) + (DW + 1)'(prod_l >>> spvm_pkg::FRAC_W);
  assign lerp_r = (DW + 1)'(a_r) + (DW + 1)'(prod_r >>> spvm_pkg::FRAC_W);
  assign src_r  = source_is_stereo ? lerp_r : lerp_l;
  assign avg    = ((DW + 2)'(lerp_l) + (DW + 2)'(src_r)) >>> 1;

  always_ff @(posedge clk) begin
    if (cmd.interp) begin
      smp_l <= output_is_stereo ? DW'(lerp_l) : DW'(avg);
      smp_r <= output_is_stereo ? DW'(src_r) : DW'(avg);
    end
  end

  // Gains: volume first, then the pan factor (or unity for mono output).
  logic signed [spvm_pkg::VOL_W:0]     vol_s;
  logic signed [spvm_pkg::PAN_W+1:0]   fac_l_wide, fac_r_wide;
  logic [spvm_pkg::FACTOR_W-1:0]       fac_l, fac_r;
  logic signed [VP_W-1:0]              vp_l, vp_r;
  logic signed [PP_W-1:0]              pp_l, pp_r;

  assign vol_s      = $signed({1'b0, volume_gain});
  assign fac_l_wide = spvm_pkg::PAN_CENTER - (spvm_pkg::PAN_W + 2)'(pan_position);
  assign fac_r_wide = spvm_pkg::PAN_CENTER + (spvm_pkg::PAN_W + 2)'(pan_position);
  assign fac_l = output_is_stereo ? spvm_pkg::FACTOR_W'(fac_l_wide) : spvm_pkg::FACTOR_MONO;
  assign fac_r = output_is_stereo ? spvm_pkg::FACTOR_W'(fac_r_wide) : spvm_pkg::FACTOR_MONO;

  always_ff @(posedge clk) begin
    if (cmd.vol) begin
      vp_l <= smp_l * vol_s;
      vp_r <= smp_r * vol_s;
    end
    if (cmd.pan) begin
      pp_l <= vp_l * $signed({1'b0, fac_l});
      pp_r <= vp_r * $signed({1'b0, fac_r});
    end
  end

  // Mix accumulation and saturation.
  logic signed [spvm_pkg::ACC_W-1:0] sum_l, sum_r;
  logic signed [spvm_pkg::MIX_W-1:0] res_l, res_r;

  assign sum_l = spvm_pkg::ACC_W'(item.mix_in_left) + spvm_pkg::ACC_W'(pp_l >>> SHIFT);
  assign sum_r = spvm_pkg::ACC_W'(item.mix_in_right) + spvm_pkg::ACC_W'(pp_r >>> SHIFT);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_l <= in_data.mix_in_left;
      res_r <= in_data.mix_in_right;
    end else if (cmd.acc) begin
      res_l <= spvm_pkg::sat_mix(sum_l);
      res_r <= spvm_pkg::sat_mix(sum_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.mix_out_left  <= res_l;
      out_data.mix_out_right <= res_r;
      out_data.voice_playing <= active;
    end
  end

  always_comb begin
    status.op       = item.opcode;
    status.addr_ok  = addr_ok;
    status.active   = active;
    status.len_zero = (len == '0);
    status.past_end = (pos_int >= len_ext);
    status.loop_en  = loop_enable;
    status.mod_busy = mod_busy;
  end

endmodule

`default_nettype wire

[sv/spvm_ctrl.sv]
// Controller state machine of the voice: sequences decode, memory access,
// remainder unit and arithmetic steps. Depends on spvm_pkg.
`default_nettype none

module spvm_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  out_stall,
  output logic                       out_valid,
  input  wire spvm_pkg::ctrl_status_t status,
  output spvm_pkg::ctrl_cmd_t        cmd
);

  spvm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spvm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      spvm_pkg::S_IDLE: begin
        if (in_valid) state_next = spvm_pkg::S_DECODE;
      end
      spvm_pkg::S_DECODE: begin
        unique case (status.op)
          spvm_pkg::OP_LOAD: begin
            state_next = status.addr_ok ? spvm_pkg::S_WRITE : spvm_pkg::S_ADDR_MOD;
          end
          spvm_pkg::OP_START, spvm_pkg::OP_STOP: begin
            state_next = spvm_pkg::S_DONE;
          end
          spvm_pkg::OP_RENDER: begin
            if (!status.active || status.len_zero) begin
              state_next = spvm_pkg::S_DONE;
            end else if (status.past_end) begin
              state_next = status.loop_en ? spvm_pkg::S_POS_MOD : spvm_pkg::S_DONE;
            end else begin
              state_next = spvm_pkg::S_READ0;
            end
          end
          default: state_next = spvm_pkg::S_DONE;
        endcase
      end
      spvm_pkg::S_ADDR_MOD: begin
        if (!status.mod_busy) state_next = spvm_pkg::S_WRITE;
      end
      spvm_pkg::S_WRITE:  state_next = spvm_pkg::S_DONE;
      spvm_pkg::S_POS_MOD: begin
        if (!status.mod_busy) state_next = spvm_pkg::S_READ0;
      end
      spvm_pkg::S_READ0:  state_next = spvm_pkg::S_READ1;
      spvm_pkg::S_READ1:  state_next = spvm_pkg::S_LERP;
      spvm_pkg::S_LERP:   state_next = spvm_pkg::S_INTERP;
      spvm_pkg::S_INTERP: state_next = spvm_pkg::S_VOL;
      spvm_pkg::S_VOL:    state_next = spvm_pkg::S_PAN;
      spvm_pkg::S_PAN:    state_next = spvm_pkg::S_ACC;
      spvm_pkg::S_ACC:    state_next = spvm_pkg::S_DONE;
      spvm_pkg::S_DONE: begin
        if (!out_valid || !out_stall) state_next = spvm_pkg::S_IDLE;
      end
      default: state_next = spvm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state != spvm_pkg::S_IDLE);
    unique case (state)
      spvm_pkg::S_IDLE: begin
        cmd.capture = in_valid;
      end
      spvm_pkg::S_DECODE: begin
        unique case (status.op)
          spvm_pkg::OP_LOAD: begin
            cmd.mod_start = !status.addr_ok;
          end
          spvm_pkg::OP_START: begin
            cmd.voice_start = 1'b1;
          end
          spvm_pkg::OP_STOP: begin
            cmd.voice_stop = 1'b1;
          end
          spvm_pkg::OP_RENDER: begin
            if (status.active && !status.len_zero && status.past_end) begin
              cmd.mod_start   = status.loop_en;
              cmd.mod_sel_pos = status.loop_en;
              cmd.voice_stop  = !status.loop_en;
            end
          end
          default: begin
          end
        endcase
      end
      spvm_pkg::S_ADDR_MOD: begin
      end
      spvm_pkg::S_WRITE: begin
        cmd.mem_write = 1'b1;
      end
      spvm_pkg::S_POS_MOD: begin
        cmd.pos_from_mod = !status.mod_busy;
      end
      spvm_pkg::S_READ0: begin
      end
      spvm_pkg::S_READ1: begin
        cmd.rd_second = 1'b1;
      end
      spvm_pkg::S_LERP: begin
        cmd.lerp = 1'b1;
      end
      spvm_pkg::S_INTERP: begin
        cmd.interp = 1'b1;
      end
      spvm_pkg::S_VOL: begin
        cmd.vol = 1'b1;
      end
      spvm_pkg::S_PAN: begin
        cmd.pan = 1'b1;
      end
      spvm_pkg::S_ACC: begin
        cmd.acc = 1'b1;
      end
      spvm_pkg::S_DONE: begin
        cmd.out_load = !out_valid || !out_stall;
      end
      default: begin
      end
    endcase
  end

  // The output register is free once its word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[sv/sample_playback_voice_mixer_unit.sv]
// One sample playback voice with linear interpolation, gains and a saturating
// mix stage. A word is taken only while the controller is idle; the result goes to
// an output register, so the next word can be taken while a result still waits.
// A render makes two reads through the single read port of the sample memory, then
// the lerp and interpolation steps, volume multiply, pan multiply and mix add, each
// in a state of their own. When the play position has run past the end with looping
// on, the 18-step remainder unit wraps it first. A load whose address lies beyond
// the memory depth has that address reduced by the same remainder unit first.
// The sample memory is not cleared; frames must be loaded before they are played.
// Depends on spvm_pkg, spvm_ctrl, spvm_datapath.
`default_nettype none

module sample_playback_voice_mixer_unit #(
  parameter int SAMPLE_DEPTH = spvm_pkg::SAMPLE_DEPTH_DEF,
  parameter int SAMPLE_BITS  = spvm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire spvm_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output spvm_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [spvm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [spvm_pkg::CFG_DATA_W-1:0] cfg_data
);

  spvm_pkg::ctrl_cmd_t    cmd;
  spvm_pkg::ctrl_status_t status;

  assign cfg_ready = 1'b1;

  spvm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .status    (status),
    .cmd       (cmd)
  );

  spvm_datapath #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[sv/spvm_checker.sv]
// Port-level checker for the voice mixer, attached to the top level by bind.
// Depends on spvm_pkg and the assertion macro header.
`default_nettype none
`include "sample_playback_voice_mixer_unit_macros.svh"

module spvm_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire spvm_pkg::out_item_t out_data
);

  // A stalled result stays offered.
  `SPVM_ASSERT_NEXT(a_out_held, clk, rst, out_valid && out_stall, out_valid)

  // A stalled result keeps its value.
  `SPVM_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(out_data))

  // The block works on one word at a time, so it stalls right after taking one.
  `SPVM_ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && !in_stall, in_stall)

  // A new result appears only at the end of a word's processing.
  `SPVM_ASSERT_SAME(a_result_from_work, clk, rst, $rose(out_valid), $past(in_stall))

endmodule

bind sample_playback_voice_mixer_unit spvm_checker u_spvm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

[sim/sample_playback_voice_mixer_unit_tb.sv]
// Self-checking testbench for the sample playback voice mixer: loads, start, stop and
// render words with random idling on both sides, checked against an in-bench predictor.
// Depends on spvm_pkg and sample_playback_voice_mixer_unit.
`timescale 1ns / 100ps

module sample_playback_voice_mixer_unit_tb;
  import spvm_pkg::*;

  typedef enum int {PLAN_IDLE, PLAN_END, PLAN_PLAY} render_plan_t;

  class voice_mix_tracker;
    logic [WORD_W-1:0] frames [65536];
    bit                loaded [65536];
    longint unsigned   cursor;
    bit                playing;
    longint unsigned   step_q816;
    longint unsigned   frame_count;
    bit                wrap_on;
    bit                src_stereo;
    bit                out_stereo;
    longint            volume;
    longint            pan;
    out_item_t         pending[$];
    int                mismatches;

    function new();
      cursor      = 0;
      playing     = 1'b0;
      step_q816   = 65536;
      frame_count = 1;
      wrap_on     = 1'b0;
      src_stereo  = 1'b0;
      out_stereo  = 1'b1;
      volume      = 4096;
      pan         = 0;
      mismatches  = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_POSITION_STEP:    step_q816 = v;
        CFG_SOUND_LENGTH:     frame_count = v[LEN_W-1:0];
        CFG_LOOP_ENABLE:      wrap_on = v[0];
        CFG_SOURCE_IS_STEREO: src_stereo = v[0];
        CFG_OUTPUT_IS_STEREO: out_stereo = v[0];
        CFG_VOLUME_GAIN:      volume = v[VOL_W-1:0];
        CFG_PAN_POSITION:     pan = $signed(v[PAN_W-1:0]);
        default: ;
      endcase
    endfunction

    // Works out what the next render does without changing any state: the
    // position after a possible wrap and the two frames it reads.
    function render_plan_t render_plan(output longint unsigned p,
                                       output int unsigned i0, output int unsigned i1);
      longint unsigned len;
      longint unsigned span;
      p = cursor;
      i0 = 0;
      i1 = 0;
      if (!playing) return PLAN_IDLE;
      len = (frame_count < 65536) ? frame_count : 65536;
      if (len == 0) return PLAN_IDLE;
      span = len << FRAC_W;
      if (p >= span) begin
        if (!wrap_on) return PLAN_END;
        p = p % span;
      end
      i0 = p >> FRAC_W;
      if (i0 + 1 < len) begin
        i1 = i0 + 1;
      end else if (wrap_on) begin
        i1 = 0;
      end else begin
        i1 = i0;
      end
      return PLAN_PLAY;
    endfunction

    function longint half(logic [HALF_W-1:0] h);
      return longint'($signed(h));
    endfunction

    function longint lerp(longint a, longint b, longint frac);
      return a + (((b - a) * frac) >>> FRAC_W);
    endfunction

    function longint clamp_mix(longint x);
      if (x > 8388607) return 8388607;
      if (x < -8388608) return -8388608;
      return x;
    endfunction

    function out_item_t predict_mix(in_item_t w);
      out_item_t       r;
      longint          ml;
      longint          mr;
      longint          sl;
      longint          sr;
      longint          gl;
      longint          gr;
      longint          frac;
      longint unsigned p;
      int unsigned     i0;
      int unsigned     i1;
      render_plan_t    plan;
      ml = $signed(w.mix_in_left);
      mr = $signed(w.mix_in_right);
      case (w.opcode)
        OP_LOAD: begin
          frames[w.load_address] = {w.load_right, w.load_left};
          loaded[w.load_address] = 1'b1;
        end
        OP_START: begin
          cursor  = 0;
          playing = 1'b1;
        end
        OP_STOP: playing = 1'b0;
        default: begin
          plan = render_plan(p, i0, i1);
          if (plan == PLAN_END) playing = 1'b0;
          if (plan == PLAN_PLAY) begin
            frac = p & 64'hFFFF;
            sl = lerp(half(frames[i0][15:0]), half(frames[i1][15:0]), frac);
            sr = src_stereo ? lerp(half(frames[i0][31:16]), half(frames[i1][31:16]), frac)
                            : sl;
            if (out_stereo) begin
              gl = volume * (32768 - pan);
              gr = volume * (32768 + pan);
            end else begin
              sl = (sl + sr) >>> 1;
              sr = sl;
              gl = volume * 65536;
              gr = gl;
            end
            ml = clamp_mix(ml + ((sl * gl) >>> (SAMPLE_BITS_DEF + 4)));
            mr = clamp_mix(mr + ((sr * gr) >>> (SAMPLE_BITS_DEF + 4)));
            cursor = (p + step_q816) & ((64'd1 << POS_W) - 1);
          end
        end
      endcase
      r.mix_out_left  = ml[MIX_W-1:0];
      r.mix_out_right = mr[MIX_W-1:0];
      r.voice_playing = playing;
      return r;
    endfunction

    function void note_word(in_item_t w);
      pending.push_back(predict_mix(w));
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_word(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report($sformatf("result %h arrived with nothing pending", got));
        return;
      end
      want = pending.pop_front();
      if (got.mix_out_left !== want.mix_out_left)
        report($sformatf("mix_out_left %h, predicted %h", got.mix_out_left,
                         want.mix_out_left));
      if (got.mix_out_right !== want.mix_out_right)
        report($sformatf("mix_out_right %h, predicted %h", got.mix_out_right,
                         want.mix_out_right));
      if (got.voice_playing !== want.voice_playing)
        report($sformatf("voice_playing %b, predicted %b", got.voice_playing,
                         want.voice_playing));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit quiet = 1'b0;
  int stall_run = 0;

  voice_mix_tracker sb = new();

  always #2 clk = ~clk;

  sample_playback_voice_mixer_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else begin
      stall_run <= pick_gap();
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_word(out_data);
  end

  function in_item_t word(op_t op, logic [15:0] a, logic [15:0] l, logic [15:0] r,
                          logic [23:0] ml, logic [23:0] mr);
    in_item_t w;
    w.opcode       = op;
    w.load_address = a;
    w.load_left    = l;
    w.load_right   = r;
    w.mix_in_left  = ml;
    w.mix_in_right = mr;
    return w;
  endfunction

  function logic [23:0] rand_mix();
    case ($urandom_range(0, 9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      default: return $urandom;
    endcase
  endfunction

  function logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return $urandom;
    endcase
  endfunction

  // Gap first, then hold the word until the block takes it.
  task send_word(in_item_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(w);
  endtask

  task send_op(op_t op);
    send_word(word(op, $urandom, $urandom, $urandom, rand_mix(), rand_mix()));
  endtask

  // Frames that the render is about to read get loaded first, so that no
  // unwritten memory entry is ever played.
  task render(logic [23:0] ml, logic [23:0] mr);
    longint unsigned p;
    int unsigned     i0;
    int unsigned     i1;
    if (sb.render_plan(p, i0, i1) == PLAN_PLAY) begin
      if (!sb.loaded[i0])
        send_word(word(OP_LOAD, i0[15:0], rand_sample(), rand_sample(), rand_mix(),
                       rand_mix()));
      if (!sb.loaded[i1])
        send_word(word(OP_LOAD, i1[15:0], rand_sample(), rand_sample(), rand_mix(),
                       rand_mix()));
    end
    send_word(word(OP_RENDER, $urandom, $urandom, $urandom, ml, mr));
  endtask

  task drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task setup(logic [23:0] step, logic [16:0] len, bit loop, bit ss, bit os,
             logic [15:0] vol, logic [15:0] pan);
    drain();
    write_reg(CFG_POSITION_STEP, step);
    write_reg(CFG_SOUND_LENGTH, {7'd0, len});
    write_reg(CFG_LOOP_ENABLE, {23'd0, loop});
    write_reg(CFG_SOURCE_IS_STEREO, {23'd0, ss});
    write_reg(CFG_OUTPUT_IS_STEREO, {23'd0, os});
    write_reg(CFG_VOLUME_GAIN, {8'd0, vol});
    write_reg(CFG_PAN_POSITION, {{8{pan[15]}}, pan});
  endtask

  initial begin
    logic [23:0] step;
    logic [16:0] len;
    logic [15:0] vol;
    logic [15:0] pan;
    int          r;
    int          n;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: mono source, stereo output, one frame, no loop.
    send_word(word(OP_LOAD, 16'h0000, 16'h7FFF, 16'h8000, 24'h7FFFFF, 24'h800000));
    send_word(word(OP_LOAD, 16'hFFFF, 16'h8000, 16'h7FFF, 24'h800000, 24'h7FFFFF));
    render(24'h7FFFFF, 24'h800000);
    send_op(OP_START);
    render(24'h7FFFFF, 24'h7FFFFF);
    render(24'h800000, 24'h800000);
    render(24'h000000, 24'hFFFFFF);
    send_op(OP_STOP);

    // Zero length: the voice stays active but adds nothing.
    setup(24'h010000, 17'd0, 1'b0, 1'b0, 1'b1, 16'd4096, 16'h0000);
    send_op(OP_START);
    render(24'h123456, 24'hEDCBA9);
    render(rand_mix(), rand_mix());

    // Zero step on a looping stereo source mixed down to mono output.
    setup(24'h000000, 17'd2, 1'b1, 1'b1, 1'b0, 16'hFFFF, 16'h8000);
    send_word(word(OP_LOAD, 16'h0001, 16'h8000, 16'h7FFF, 24'h0, 24'h0));
    send_op(OP_START);
    render(24'h800000, 24'h7FFFFF);
    render(rand_mix(), rand_mix());

    // Largest step and full-depth length, panned hard right.
    setup(24'hFFFFFF, 17'd65536, 1'b1, 1'b0, 1'b1, 16'd4096, 16'h7FFF);
    send_op(OP_START);
    repeat (4) render(rand_mix(), rand_mix());

    // Short loop that wraps by remainder, stereo in and out.
    setup(24'h028000, 17'd3, 1'b1, 1'b1, 1'b1, 16'd2048, 16'hC000);
    send_op(OP_START);
    repeat (4) render(rand_mix(), rand_mix());

    for (int ph = 0; ph < 12; ph++) begin
      case ((ph < 2) ? ph : $urandom_range(2, 9))
        0: step = 24'd1;
        1: step = 24'hFFFFFF;
        2: step = $urandom_range(0, 16777215);
        3: step = $urandom_range(24'h100000, 24'h400000);
        default: step = $urandom_range(24'h001000, 24'h028000);
      endcase
      case ($urandom_range(0, 9))
        0: len = 17'd65536;
        1: len = 17'd1;
        2: len = $urandom_range(1, 65536);
        default: len = $urandom_range(2, 48);
      endcase
      case ((ph < 2) ? ph : $urandom_range(2, 6))
        0: vol = 16'd0;
        1: vol = 16'hFFFF;
        default: vol = $urandom;
      endcase
      case ($urandom_range(0, 5))
        0: pan = 16'h8000;
        1: pan = 16'h7FFF;
        2: pan = 16'h0000;
        default: pan = $urandom;
      endcase
      setup(step, len, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
            vol, pan);
      quiet = (ph == 2) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 95; i++) begin
        r = $urandom_range(0, 99);
        if (!sb.playing && r < 35) begin
          send_op(OP_START);
        end else if (r < 70) begin
          render(rand_mix(), rand_mix());
        end else if (r < 82) begin
          send_word(word(OP_LOAD, $urandom, rand_sample(), rand_sample(), rand_mix(),
                         rand_mix()));
        end else if (r < 88) begin
          send_op(OP_START);
        end else if (r < 92) begin
          send_op(OP_STOP);
        end else begin
          render(rand_mix(), rand_mix());
        end
      end
      quiet = 1'b0;
    end

    in_valid <= 1'b0;
    for (n = 0; n < 100000 && sb.pending.size() != 0; n++) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending.size()));
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
